>>> rtl/core/imm_pkg.sv
`default_nettype none

package imm_pkg;

    localparam int ELEM_W   = 32;
    localparam int IDX_W    = 4;
    localparam int SIZE_W   = 5;
    localparam int SIZE_CAP = 16;
    localparam int CFG_ADDR_W = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // request codes; code 3 is unused and dropped
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_ROW    = 2'd2;

    // register index as decoded from paddr[2]
    localparam logic REG_ACTIVE_SIZE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_WAIT,
        ST_DRAIN
    } state_t;

    // element of A travelling down the cell chain
    typedef struct packed {
        logic              vld;
        logic              first;
        logic              last;
        logic [ELEM_W-1:0] a;
        logic [IDX_W-1:0]  k;
    } link_t;

    typedef struct packed {
        logic              done;
        logic [ELEM_W-1:0] acc;
    } cell_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/integer_matrix_multiply.sv
// Square integer matrix multiply C = A x B over signed 32-bit elements.
// Input channel (in_valid/in_stall): req_type selects a load of one element
// of A or of B at row_index/col_index, or a request for row row_index of C.
// Loads are taken and produce nothing. A row request emits
// n results on the output channel (out_valid/out_stall), column 0 first,
// last_in_row set on column n-1, where n is active_size clamped to 1..min(MAX_SIZE, 16).
// Sums wrap modulo 2^32.
// Each column of C has its own MAC cell holding that column of B; the row of
// A is read one element a cycle and passed down the cell chain, so cell j
// works in the cycle after cell j-1. A row request runs in order: the reads
// of A, the chain finishing its last column, the hand-out of the results,
// then a return to idle. One row request is in flight at a time; in_stall
// stays high until the last result is in the output register.
// A stalled output holds its result; the drain waits on it.
// active_size is written through the APB port at address 0; the user must
// do so only while the block is idle, which the block itself does not enforce.
// Reset clears control state and sets active_size to 16; matrix storage is
// not cleared, and every element must be loaded before it is used.
`default_nettype none

module integer_matrix_multiply #(
    parameter int MAX_SIZE = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           req_type,
    input  logic [imm_pkg::IDX_W-1:0]            row_index,
    input  logic [imm_pkg::IDX_W-1:0]            col_index,
    input  logic signed [imm_pkg::ELEM_W-1:0]    element_value,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [imm_pkg::IDX_W-1:0]            out_row,
    output logic [imm_pkg::IDX_W-1:0]            out_col,
    output logic signed [imm_pkg::ELEM_W-1:0]    product_value,
    output logic                                 last_in_row,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [imm_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    import imm_pkg::*;

    localparam int NCELL   = (MAX_SIZE < SIZE_CAP) ? MAX_SIZE : SIZE_CAP;
    localparam int LG      = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int A_DEPTH = NCELL * NCELL;
    localparam int AW      = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;

    state_t            state_reg;
    state_t            state_next;

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] eff_size;

    logic              in_ok;
    logic              load_in_range;
    logic              row_ok;
    logic              start;
    logic              feed_go;
    logic              out_load;

    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  row_next;
    logic [LG-1:0]     last_col_reg;
    logic [LG-1:0]     last_col_next;
    logic [LG-1:0]     k_reg;
    logic [LG-1:0]     k_next;
    logic [LG-1:0]     col_cnt_reg;
    logic [LG-1:0]     col_cnt_next;

    logic              feed_vld_reg;
    logic              feed_first_reg;
    logic              feed_last_reg;
    logic [IDX_W-1:0]  feed_k_reg;

    logic              a_we;
    logic [AW-1:0]     a_waddr;
    logic [AW-1:0]     a_raddr;
    logic [ELEM_W-1:0] a_rd;

    link_t             link [NCELL+1];
    cell_stat_t        stat [NCELL];

    logic              out_vld_reg;
    logic              out_vld_next;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;
    logic [ELEM_W-1:0] out_prod_reg;
    logic              out_last_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_ACTIVE_SIZE)
        begin
            size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACTIVE_SIZE) ? {{(32-SIZE_W){1'b0}}, size_reg} : '0;

    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (size_reg > SIZE_W'(NCELL))
        begin
            eff_size = SIZE_W'(NCELL);
        end
        else
        begin
            eff_size = size_reg;
        end
    end

    assign in_ok         = in_valid && !in_stall;
    assign load_in_range = ({1'b0, row_index} < SIZE_W'(NCELL))
                        && ({1'b0, col_index} < SIZE_W'(NCELL));
    assign row_ok        = {1'b0, row_index} < eff_size;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ok && req_type == REQ_ROW && row_ok)
                begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                if (k_reg == last_col_reg)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (stat[last_col_reg].done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_load && col_cnt_reg == last_col_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall = 1'b1;
        start    = 1'b0;
        feed_go  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                start    = in_valid && req_type == REQ_ROW && row_ok;
            end
            ST_FEED:
            begin
                feed_go = 1'b1;
            end
            ST_WAIT:
            begin
                feed_go = 1'b0;
            end
            ST_DRAIN:
            begin
                out_load = !out_vld_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        row_next      = start ? row_index : row_reg;
        last_col_next = start ? LG'(eff_size - SIZE_W'(1)) : last_col_reg;
        k_next        = start ? '0 : (feed_go ? k_reg + LG'(1) : k_reg);
        col_cnt_next  = start ? '0 : (out_load ? col_cnt_reg + LG'(1) : col_cnt_reg);
        out_vld_next  = out_load || (out_vld_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            feed_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            feed_vld_reg <= feed_go;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        last_col_reg   <= last_col_next;
        k_reg          <= k_next;
        col_cnt_reg    <= col_cnt_next;
        feed_first_reg <= (k_reg == '0);
        feed_last_reg  <= (k_reg == last_col_reg);
        feed_k_reg     <= IDX_W'(k_reg);
        if (out_load)
        begin
            out_row_reg  <= row_reg;
            out_col_reg  <= IDX_W'(col_cnt_reg);
            out_prod_reg <= stat[col_cnt_reg].acc;
            out_last_reg <= (col_cnt_reg == last_col_reg);
        end
    end

    // matrix A, row-major
    assign a_we    = in_ok && req_type == REQ_LOAD_A && load_in_range;
    assign a_waddr = AW'(AW'(row_index) * AW'(NCELL) + AW'(col_index));
    assign a_raddr = AW'(AW'(row_reg) * AW'(NCELL) + AW'(k_reg));

    imm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (A_DEPTH)
    ) u_store_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (element_value),
        .raddr (a_raddr),
        .rdata (a_rd)
    );

    always_comb
    begin
        link[0].vld   = feed_vld_reg;
        link[0].first = feed_first_reg;
        link[0].last  = feed_last_reg;
        link[0].a     = a_rd;
        link[0].k     = feed_k_reg;
    end

    for (genvar j = 0; j < NCELL; j++)
    begin : g_cell
        logic b_we;

        assign b_we = in_ok && req_type == REQ_LOAD_B && load_in_range
                   && col_index == IDX_W'(j);

        imm_cell #(
            .DEPTH (NCELL)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (link[j]),
            .link_out (link[j+1]),
            .b_we     (b_we),
            .b_waddr  (row_index),
            .b_wdata  (element_value),
            .stat     (stat[j])
        );
    end

    assign out_valid     = out_vld_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = out_prod_reg;
    assign last_in_row   = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/core/imm_ram.sv
`default_nettype none

module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/imm_cell.sv
`default_nettype none

module imm_cell #(
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  imm_pkg::link_t               link_in,
    output imm_pkg::link_t               link_out,
    input  logic                         b_we,
    input  logic [imm_pkg::IDX_W-1:0]    b_waddr,
    input  logic [imm_pkg::ELEM_W-1:0]   b_wdata,
    output imm_pkg::cell_stat_t          stat
);

    import imm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              s1_vld_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic [ELEM_W-1:0] s1_a_reg;
    logic [IDX_W-1:0]  s1_k_reg;
    logic [ELEM_W-1:0] b_rd;

    logic              v2_reg;
    logic              f2_reg;
    logic              l2_reg;
    logic [ELEM_W-1:0] prod_reg;
    logic [ELEM_W-1:0] prod_next;

    logic [ELEM_W-1:0] acc_reg;
    logic [ELEM_W-1:0] acc_next;
    logic              done_reg;
    logic              done_next;

    // column of B held by this cell, addressed by row k
    imm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_b_col (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr[AW-1:0]),
        .wdata (b_wdata),
        .raddr (link_in.k[AW-1:0]),
        .rdata (b_rd)
    );

    // low 32 bits of the product are the same signed or unsigned
    assign prod_next = s1_a_reg * b_rd;
    assign acc_next  = f2_reg ? prod_reg : acc_reg + prod_reg;
    assign done_next = v2_reg && l2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            v2_reg     <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= link_in.vld;
            v2_reg     <= s1_vld_reg;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= link_in.first;
        s1_last_reg  <= link_in.last;
        s1_a_reg     <= link_in.a;
        s1_k_reg     <= link_in.k;
        f2_reg       <= s1_first_reg;
        l2_reg       <= s1_last_reg;
        prod_reg     <= prod_next;
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // hand the A element to the next column in the cycle after it arrives
    always_comb
    begin
        link_out.vld   = s1_vld_reg;
        link_out.first = s1_first_reg;
        link_out.last  = s1_last_reg;
        link_out.a     = s1_a_reg;
        link_out.k     = s1_k_reg;
    end

    always_comb
    begin
        stat.done = done_reg;
        stat.acc  = acc_reg;
    end

endmodule

`default_nettype wire

>>> rtl/core/imm_checker.sv
`default_nettype none

module imm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [3:0]  out_row,
    input wire logic [3:0]  out_col,
    input wire logic [31:0] product_value,
    input wire logic        last_in_row
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(product_value)
                                   && $stable(out_col) && $stable(out_row))
        else $error("stalled result changed");

    // within a row, columns follow back to back in rising order
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_in_row |=> out_valid
            && out_col == $past(out_col) + 4'd1 && out_row == $past(out_row))
        else $error("row results out of order");

    // no new request is taken while a result before the last of its row is shown
    a_busy_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_in_row |-> in_stall)
        else $error("request taken in the middle of a row");

    // a row always begins at column zero
    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_in_row |=> !out_valid || out_col == 4'd0)
        else $error("row did not start at column zero");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_col       (out_col),
    .product_value (product_value),
    .last_in_row   (last_in_row)
);

`default_nettype wire
